// ----- rtl/hpp_pkg.sv -----
package hpp_pkg;

    // Field widths
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned TEMP_W  = 12;
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned TIMER_W = 8;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 3;

    // Only the low 16 bits of the PID sum are ever looked at, so the
    // error memory and the products are kept at this width.
    localparam int unsigned PID_W = 16;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 8;

    // PWM period in counter steps (full duty)
    localparam logic [DUTY_W-1:0] PWM_STEPS = 7'd100;

    // Heat level codes
    localparam logic [LEVEL_W-1:0] HEAT_OFF   = 2'd0;
    localparam logic [LEVEL_W-1:0] HEAT_ONE   = 2'd1;
    localparam logic [LEVEL_W-1:0] HEAT_TWO   = 2'd2;
    localparam logic [LEVEL_W-1:0] HEAT_THREE = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SP_ONE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SP_TWO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SP_THREE = 3'd2;
    localparam logic [IDX_W-1:0] REG_KP       = 3'd3;
    localparam logic [IDX_W-1:0] REG_KI       = 3'd4;
    localparam logic [IDX_W-1:0] REG_KD       = 3'd5;
    localparam logic [IDX_W-1:0] REG_MARGIN   = 3'd6;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd7;

    // Register reset values
    localparam logic [TEMP_W-1:0]  SP_ONE_RST   = 12'd700;
    localparam logic [TEMP_W-1:0]  SP_TWO_RST   = 12'd780;
    localparam logic [TEMP_W-1:0]  SP_THREE_RST = 12'd930;
    localparam logic [GAIN_W-1:0]  KP_RST       = 16'd18;
    localparam logic [GAIN_W-1:0]  KI_RST       = 16'd0;
    localparam logic [GAIN_W-1:0]  KD_RST       = 16'd0;
    localparam logic [TEMP_W-1:0]  MARGIN_RST   = 12'd30;
    localparam logic [TIMER_W-1:0] PERIOD_RST   = 8'd100;

endpackage

// ----- rtl/heater_pid_pwm_controller.sv -----
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  heat_level[1:0], temperature[13:2]
// m_axis    out  m_axis_tvalid/m_axis_tready  duty[6:0], heater_on[7]
// cfg       in   cfg_wr_en (no wait)          cfg_index selects, cfg_data value
//
// One request per cycle sustained while m_axis_tready stays high; a request is
// held in the input register, then its result in the state/result registers.
// The path between them is the PID sum: three 16x16 multiplies in parallel.
// Reset clears all control state and loads the register defaults.
// When m_axis_tready is low the result holds and one more request is
// buffered in the input register before s_axis_tready drops.
module heater_pid_pwm_controller
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] heat_level, [13:2] temperature, [15:14] zero
    input  logic [hpp_pkg::IN_DATA_W-1:0]     s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [6:0] duty, [7] heater_on
    output logic [hpp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

    input  logic                              cfg_wr_en,
    input  logic [hpp_pkg::IDX_W-1:0]         cfg_index,
    input  logic [hpp_pkg::CFG_W-1:0]         cfg_data
);

    // Configuration registers
    logic [hpp_pkg::TEMP_W-1:0]  sp_one_reg;
    logic [hpp_pkg::TEMP_W-1:0]  sp_two_reg;
    logic [hpp_pkg::TEMP_W-1:0]  sp_three_reg;
    logic [hpp_pkg::GAIN_W-1:0]  kp_reg;
    logic [hpp_pkg::GAIN_W-1:0]  ki_reg;
    logic [hpp_pkg::GAIN_W-1:0]  kd_reg;
    logic [hpp_pkg::TEMP_W-1:0]  margin_reg;
    logic [hpp_pkg::TIMER_W-1:0] period_reg;

    // Input stage
    logic                         in_valid_reg;
    logic [hpp_pkg::LEVEL_W-1:0]  in_level_reg;
    logic [hpp_pkg::TEMP_W-1:0]   in_temp_reg;

    // Controller state; duty and drive are also the result payload
    logic                         out_valid_reg;
    logic [hpp_pkg::TIMER_W-1:0]  timer_reg,   timer_next;
    logic [hpp_pkg::DUTY_W-1:0]   pwm_cnt_reg, pwm_cnt_next;
    logic [hpp_pkg::DUTY_W-1:0]   duty_reg,    duty_next;
    logic [hpp_pkg::PID_W-1:0]    esum_reg,    esum_next;
    logic [hpp_pkg::PID_W-1:0]    perr_reg,    perr_next;
    logic                         drive_reg,   drive_next;

    logic in_take;
    logic step;

    // Datapath
    logic [hpp_pkg::TEMP_W-1:0]  setpoint;
    logic                        below;
    logic [hpp_pkg::TEMP_W-1:0]  gap;
    logic [hpp_pkg::TIMER_W-1:0] timer_inc;
    logic [hpp_pkg::PID_W-1:0]   err;
    logic [hpp_pkg::PID_W-1:0]   esum_upd;
    logic [hpp_pkg::PID_W-1:0]   derr;
    logic [hpp_pkg::PID_W-1:0]   prod_p;
    logic [hpp_pkg::PID_W-1:0]   prod_i;
    logic [hpp_pkg::PID_W-1:0]   prod_d;
    logic [hpp_pkg::PID_W-1:0]   pid_raw;
    logic [hpp_pkg::DUTY_W-1:0]  pid_duty;
    logic [hpp_pkg::DUTY_W-1:0]  cnt_base;
    logic [hpp_pkg::DUTY_W-1:0]  cnt_inc;

    // Handshake: the state advances when the result slot is free or drains
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {drive_reg, duty_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_one_reg   <= hpp_pkg::SP_ONE_RST;
            sp_two_reg   <= hpp_pkg::SP_TWO_RST;
            sp_three_reg <= hpp_pkg::SP_THREE_RST;
            kp_reg       <= hpp_pkg::KP_RST;
            ki_reg       <= hpp_pkg::KI_RST;
            kd_reg       <= hpp_pkg::KD_RST;
            margin_reg   <= hpp_pkg::MARGIN_RST;
            period_reg   <= hpp_pkg::PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hpp_pkg::REG_SP_ONE:   sp_one_reg   <= cfg_data[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_SP_TWO:   sp_two_reg   <= cfg_data[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_SP_THREE: sp_three_reg <= cfg_data[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_KP:       kp_reg       <= cfg_data[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_KI:       ki_reg       <= cfg_data[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_KD:       kd_reg       <= cfg_data[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_MARGIN:   margin_reg   <= cfg_data[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_PERIOD:   period_reg   <= cfg_data[hpp_pkg::TIMER_W-1:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_level_reg <= hpp_pkg::HEAT_OFF;
            in_temp_reg  <= '0;
        end
        else if (in_take)
        begin
            in_level_reg <= s_axis_tdata[hpp_pkg::LEVEL_W-1:0];
            in_temp_reg  <= s_axis_tdata[hpp_pkg::LEVEL_W +: hpp_pkg::TEMP_W];
        end
    end

    // Setpoint select and error terms
    always_comb
    begin
        unique case (in_level_reg)
            hpp_pkg::HEAT_ONE:   setpoint = sp_one_reg;
            hpp_pkg::HEAT_TWO:   setpoint = sp_two_reg;
            hpp_pkg::HEAT_THREE: setpoint = sp_three_reg;
            hpp_pkg::HEAT_OFF:   setpoint = sp_one_reg;
        endcase
    end

    assign below     = setpoint > in_temp_reg;
    assign gap       = setpoint - in_temp_reg;
    assign timer_inc = timer_reg + 8'd1;
    assign err       = {{(hpp_pkg::PID_W - hpp_pkg::TEMP_W){1'b0}}, gap};
    assign esum_upd  = esum_reg + err;
    assign derr      = err - perr_reg;

    // PID sum, low 16 bits only
    assign prod_p  = kp_reg * err;
    assign prod_i  = ki_reg * esum_upd;
    assign prod_d  = kd_reg * derr;
    assign pid_raw = prod_p + prod_i + prod_d;

    // Negative reads as zero, large values clamp to full duty
    always_comb
    begin
        priority if (pid_raw[hpp_pkg::PID_W-1])
            pid_duty = '0;
        else if (pid_raw > {{(hpp_pkg::PID_W - hpp_pkg::DUTY_W){1'b0}}, hpp_pkg::PWM_STEPS})
            pid_duty = hpp_pkg::PWM_STEPS;
        else
            pid_duty = pid_raw[hpp_pkg::DUTY_W-1:0];
    end

    // Next controller state for the item in the input register
    always_comb
    begin
        timer_next   = timer_reg;
        pwm_cnt_next = pwm_cnt_reg;
        duty_next    = duty_reg;
        esum_next    = esum_reg;
        perr_next    = perr_reg;
        drive_next   = drive_reg;
        cnt_base     = pwm_cnt_reg;
        cnt_inc      = '0;

        if (in_level_reg == hpp_pkg::HEAT_OFF)
        begin
            timer_next   = '0;
            pwm_cnt_next = '0;
            duty_next    = '0;
            drive_next   = 1'b0;
        end
        else
        begin
            // duty selection
            if (below)
            begin
                if (gap >= margin_reg)
                begin
                    duty_next = hpp_pkg::PWM_STEPS;
                end
                else if (timer_inc >= period_reg)
                begin
                    timer_next = '0;
                    cnt_base   = '0;
                    duty_next  = pid_duty;
                    esum_next  = esum_upd;
                    perr_next  = err;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            else
            begin
                duty_next = '0;
            end

            // PWM drive; drive level holds across the wrap
            cnt_inc = cnt_base + 7'd1;
            priority if (cnt_inc <= duty_next)
            begin
                pwm_cnt_next = cnt_inc;
                drive_next   = 1'b1;
            end
            else if (cnt_inc <= hpp_pkg::PWM_STEPS)
            begin
                pwm_cnt_next = cnt_inc;
                drive_next   = 1'b0;
            end
            else
            begin
                pwm_cnt_next = '0;
            end
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            timer_reg     <= '0;
            pwm_cnt_reg   <= '0;
            duty_reg      <= '0;
            esum_reg      <= '0;
            perr_reg      <= '0;
            drive_reg     <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                timer_reg     <= timer_next;
                pwm_cnt_reg   <= pwm_cnt_next;
                duty_reg      <= duty_next;
                esum_reg      <= esum_next;
                perr_reg      <= perr_next;
                drive_reg     <= drive_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- bench/heater_pid_pwm_controller_test.sv -----
module heater_pid_pwm_controller_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 56;
    localparam int SETTLE_TICKS = 4;

    // Expected content of one result
    typedef struct packed {
        logic [hpp_pkg::DUTY_W-1:0] duty;
        logic                       heater_on;
    } heat_result_t;

    // Tracks controller state, predicts each result and checks it
    class duty_tracker;
        logic [hpp_pkg::TEMP_W-1:0]  sp_one;
        logic [hpp_pkg::TEMP_W-1:0]  sp_two;
        logic [hpp_pkg::TEMP_W-1:0]  sp_three;
        logic [hpp_pkg::TEMP_W-1:0]  margin;
        logic [hpp_pkg::GAIN_W-1:0]  kp;
        logic [hpp_pkg::GAIN_W-1:0]  ki;
        logic [hpp_pkg::GAIN_W-1:0]  kd;
        logic [hpp_pkg::TIMER_W-1:0] period;
        logic [hpp_pkg::TIMER_W-1:0] timer;
        logic [hpp_pkg::DUTY_W-1:0]  pwm_count;
        logic [hpp_pkg::DUTY_W-1:0]  duty;
        logic [31:0]                 err_sum;
        logic [31:0]                 last_err;
        logic                        drive;
        heat_result_t                expected_q[$];
        int                          mismatches;

        function new();
            sp_one     = hpp_pkg::SP_ONE_RST;
            sp_two     = hpp_pkg::SP_TWO_RST;
            sp_three   = hpp_pkg::SP_THREE_RST;
            kp         = hpp_pkg::KP_RST;
            ki         = hpp_pkg::KI_RST;
            kd         = hpp_pkg::KD_RST;
            margin     = hpp_pkg::MARGIN_RST;
            period     = hpp_pkg::PERIOD_RST;
            timer      = '0;
            pwm_count  = '0;
            duty       = '0;
            err_sum    = '0;
            last_err   = '0;
            drive      = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [hpp_pkg::IDX_W-1:0] idx,
                                logic [hpp_pkg::CFG_W-1:0] val);
            case (idx)
                hpp_pkg::REG_SP_ONE:   sp_one   = val[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_SP_TWO:   sp_two   = val[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_SP_THREE: sp_three = val[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_KP:       kp       = val[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_KI:       ki       = val[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_KD:       kd       = val[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_MARGIN:   margin   = val[hpp_pkg::TEMP_W-1:0];
                hpp_pkg::REG_PERIOD:   period   = val[hpp_pkg::TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [hpp_pkg::TEMP_W-1:0] setpoint_for(logic [hpp_pkg::LEVEL_W-1:0] lvl);
            case (lvl)
                hpp_pkg::HEAT_ONE: return sp_one;
                hpp_pkg::HEAT_TWO: return sp_two;
                default:           return sp_three;
            endcase
        endfunction

        // PID step, everything modulo 2^32; only the low 16 bits decide
        function logic [hpp_pkg::DUTY_W-1:0] pid_step(logic [hpp_pkg::TEMP_W-1:0] sp,
                                                      logic [hpp_pkg::TEMP_W-1:0] tmp);
            logic [31:0] err;
            logic [31:0] derr;
            logic [31:0] raw;
            err      = 32'(sp) - 32'(tmp);
            err_sum  = err_sum + err;
            derr     = err - last_err;
            last_err = err;
            raw = 32'(kp) * err + 32'(ki) * err_sum + 32'(kd) * derr;
            if (raw[15])
                return '0;
            if (raw[15:0] > 16'(hpp_pkg::PWM_STEPS))
                return hpp_pkg::PWM_STEPS;
            return raw[hpp_pkg::DUTY_W-1:0];
        endfunction

        // One tick: update state and queue the expected result
        function void take_request(logic [hpp_pkg::LEVEL_W-1:0] lvl,
                                   logic [hpp_pkg::TEMP_W-1:0] tmp);
            logic [hpp_pkg::TEMP_W-1:0] sp;
            heat_result_t               r;
            if (lvl == hpp_pkg::HEAT_OFF)
            begin
                timer     = '0;
                pwm_count = '0;
                duty      = '0;
                drive     = 1'b0;
            end
            else
            begin
                sp = setpoint_for(lvl);
                if (sp > tmp)
                begin
                    if (sp - tmp >= margin)
                        duty = hpp_pkg::PWM_STEPS;
                    else
                    begin
                        timer = timer + 8'd1;
                        if (timer >= period)
                        begin
                            timer     = '0;
                            pwm_count = '0;
                            duty      = pid_step(sp, tmp);
                        end
                    end
                end
                else
                    duty = '0;

                // software PWM; drive kept on wrap
                pwm_count = pwm_count + 7'd1;
                if (pwm_count <= duty)
                    drive = 1'b1;
                else if (pwm_count <= hpp_pkg::PWM_STEPS)
                    drive = 1'b0;
                else
                    pwm_count = '0;
            end
            r.duty      = duty;
            r.heater_on = drive;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [hpp_pkg::OUT_DATA_W-1:0] data);
            heat_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: tdata %h", data);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (data[hpp_pkg::DUTY_W-1:0] !== e.duty)
            begin
                $error("duty: expected %0d, actual %0d", e.duty, data[hpp_pkg::DUTY_W-1:0]);
                mismatches++;
            end
            if (data[hpp_pkg::DUTY_W] !== e.heater_on)
            begin
                $error("heater_on: expected %0b, actual %0b", e.heater_on,
                       data[hpp_pkg::DUTY_W]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [hpp_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [hpp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            cfg_wr_en;
    logic [hpp_pkg::IDX_W-1:0]       cfg_index;
    logic [hpp_pkg::CFG_W-1:0]       cfg_data;

    duty_tracker sb;
    bit          tx_calm;
    bit          rx_calm;
    int          cycle_count;
    int          run_left;
    logic [hpp_pkg::LEVEL_W-1:0] run_level;

    heater_pid_pwm_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Send one request after a random gap; note it once taken
    task automatic send_request(input logic [hpp_pkg::LEVEL_W-1:0] lvl,
                                input logic [hpp_pkg::TEMP_W-1:0] tmp);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, tmp, lvl};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.take_request(lvl, tmp);
    endtask

    // Stop sending and wait until every result is back and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Leaves the enable high; caller lowers it after the last write
    task automatic write_reg(input logic [hpp_pkg::IDX_W-1:0] idx,
                             input logic [hpp_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // 12-bit register value, junk in the unused upper bits
    function automatic logic [hpp_pkg::CFG_W-1:0] pick_setpoint();
        logic [hpp_pkg::TEMP_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            default: v = 12'($urandom_range(0, 4095));
        endcase
        return {4'($urandom_range(0, 15)), v};
    endfunction

    function automatic logic [hpp_pkg::CFG_W-1:0] pick_margin();
        logic [hpp_pkg::TEMP_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = 12'($urandom_range(1, 64));
            default: v = 12'($urandom_range(0, 4095));
        endcase
        return {4'($urandom_range(0, 15)), v};
    endfunction

    function automatic logic [hpp_pkg::CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return 16'($urandom_range(0, 64));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [hpp_pkg::CFG_W-1:0] pick_period();
        logic [hpp_pkg::TIMER_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 8'd1;
            2:       v = '1;
            default: v = 8'($urandom_range(1, 12));
        endcase
        return {8'($urandom_range(0, 255)), v};
    endfunction

    // Reading placed mostly inside the band just below the setpoint
    function automatic logic [hpp_pkg::TEMP_W-1:0] near_reading(
        logic [hpp_pkg::LEVEL_W-1:0] lvl);
        int sp;
        int m;
        int gap;
        int t;
        sp = int'(sb.setpoint_for(lvl));
        m  = int'(sb.margin);
        case ($urandom_range(0, 9))
            7:       gap = m;
            8:       gap = 0;
            9:       gap = -int'($urandom_range(1, 5));
            default: gap = (m >= 2) ? int'($urandom_range(1, m - 1)) : 1;
        endcase
        t = sp - gap;
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return t[hpp_pkg::TEMP_W-1:0];
    endfunction

    // Result side: random stall before each result
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_calm ? 0 : int'($urandom_range(0, 13));
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial
    begin
        int pick;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        run_left      = 0;
        run_level     = hpp_pkg::HEAT_ONE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: off, full duty, at/above setpoint, near band, timer hold
        send_request(hpp_pkg::HEAT_OFF, 12'd0);
        send_request(hpp_pkg::HEAT_ONE, 12'd0);
        send_request(hpp_pkg::HEAT_THREE, 12'hFFF);
        send_request(hpp_pkg::HEAT_TWO, 12'd780);
        send_request(hpp_pkg::HEAT_ONE, 12'd699);
        send_request(hpp_pkg::HEAT_ONE, 12'hFFF);
        send_request(hpp_pkg::HEAT_ONE, 12'd0);

        // Zero update period: PID on every near tick
        drain();
        write_reg(hpp_pkg::REG_PERIOD, 16'd0);
        cfg_wr_en <= 1'b0;
        send_request(hpp_pkg::HEAT_ONE, 12'd690);
        send_request(hpp_pkg::HEAT_ONE, 12'd695);

        // Period lowered below a running timer
        drain();
        write_reg(hpp_pkg::REG_PERIOD, 16'd200);
        cfg_wr_en <= 1'b0;
        send_request(hpp_pkg::HEAT_TWO, 12'd775);
        send_request(hpp_pkg::HEAT_TWO, 12'd775);
        send_request(hpp_pkg::HEAT_TWO, 12'd775);
        drain();
        write_reg(hpp_pkg::REG_PERIOD, 16'd2);
        cfg_wr_en <= 1'b0;
        send_request(hpp_pkg::HEAT_TWO, 12'd775);
        // error memory survives an off tick
        send_request(hpp_pkg::HEAT_OFF, 12'd775);
        send_request(hpp_pkg::HEAT_TWO, 12'd779);
        send_request(hpp_pkg::HEAT_TWO, 12'd779);

        // Zero margin: any reading below the setpoint is full duty
        drain();
        write_reg(hpp_pkg::REG_MARGIN, 16'd0);
        cfg_wr_en <= 1'b0;
        send_request(hpp_pkg::HEAT_THREE, 12'd929);

        // Largest gains with a wide near band
        drain();
        write_reg(hpp_pkg::REG_KP, 16'hFFFF);
        write_reg(hpp_pkg::REG_KI, 16'hFFFF);
        write_reg(hpp_pkg::REG_KD, 16'hFFFF);
        write_reg(hpp_pkg::REG_MARGIN, 16'd4095);
        write_reg(hpp_pkg::REG_PERIOD, 16'd1);
        cfg_wr_en <= 1'b0;
        send_request(hpp_pkg::HEAT_ONE, 12'd699);
        send_request(hpp_pkg::HEAT_ONE, 12'd0);
        send_request(hpp_pkg::HEAT_THREE, 12'd0);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (ph == 0)
            begin
                write_reg(hpp_pkg::REG_SP_ONE, 16'hFFFF);
                write_reg(hpp_pkg::REG_SP_TWO, 16'hFFFF);
                write_reg(hpp_pkg::REG_SP_THREE, 16'hFFFF);
                write_reg(hpp_pkg::REG_KP, 16'hFFFF);
                write_reg(hpp_pkg::REG_KI, 16'hFFFF);
                write_reg(hpp_pkg::REG_KD, 16'hFFFF);
                write_reg(hpp_pkg::REG_MARGIN, 16'hFFFF);
                write_reg(hpp_pkg::REG_PERIOD, 16'hFFFF);
            end
            else if (ph == 1)
            begin
                write_reg(hpp_pkg::REG_SP_ONE, 16'd0);
                write_reg(hpp_pkg::REG_SP_TWO, 16'd0);
                write_reg(hpp_pkg::REG_SP_THREE, 16'd0);
                write_reg(hpp_pkg::REG_KP, 16'd0);
                write_reg(hpp_pkg::REG_KI, 16'd0);
                write_reg(hpp_pkg::REG_KD, 16'd0);
                write_reg(hpp_pkg::REG_MARGIN, 16'd0);
                write_reg(hpp_pkg::REG_PERIOD, 16'd0);
            end
            else
            begin
                write_reg(hpp_pkg::REG_SP_ONE, pick_setpoint());
                write_reg(hpp_pkg::REG_SP_TWO, pick_setpoint());
                write_reg(hpp_pkg::REG_SP_THREE, pick_setpoint());
                write_reg(hpp_pkg::REG_KP, pick_gain());
                write_reg(hpp_pkg::REG_KI, pick_gain());
                write_reg(hpp_pkg::REG_KD, pick_gain());
                write_reg(hpp_pkg::REG_MARGIN, pick_margin());
                write_reg(hpp_pkg::REG_PERIOD, pick_period());
            end
            cfg_wr_en <= 1'b0;

            // Runs at one level near its setpoint, with some noise and off ticks
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (run_left == 0)
                begin
                    run_level = 2'($urandom_range(1, 3));
                    run_left  = int'($urandom_range(4, 30));
                end
                run_left--;
                pick = int'($urandom_range(0, 99));
                if (pick < 8)
                    send_request(hpp_pkg::HEAT_OFF, 12'($urandom_range(0, 4095)));
                else if (pick < 18)
                    send_request(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
                else
                    send_request(run_level, near_reading(run_level));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
